FILE: rtl/core/pprr_pkg.sv
// shared types, constants and helpers for the point-to-plane residual pipeline
package pprr_pkg;

	typedef logic signed [31:0] q16_t;

	localparam q16_t SAT_POS    = 32'sh7fffffff;
	localparam q16_t SAT_NEG    = 32'sh80000000;
	localparam q16_t SAT_DIFF   = 32'sd2147483647;
	localparam q16_t Q16_ONE    = 32'sd65536;
	localparam q16_t KEEP_MIN_W = 32'sd6553;

	localparam int MAG_W   = 30;
	localparam int ROOT_W  = 64;
	localparam int NNUM_W  = 60;
	localparam int NDEN_W  = 32;
	localparam int NQ_W    = 29;
	localparam int N_W     = 30;
	localparam int DIST_W  = 35;
	localparam int RNUM_W  = 56;
	localparam int RDEN_W  = 36;
	localparam int RQ_W    = 33;

	localparam logic [20:0] RATIO_MUL = 21'd1179648;

	typedef struct packed {
		q16_t adjacent_scan_z;
		q16_t adjacent_scan_y;
		q16_t adjacent_scan_x;
		q16_t same_scan_z;
		q16_t same_scan_y;
		q16_t same_scan_x;
		q16_t near_z;
		q16_t near_y;
		q16_t near_x;
		q16_t point_z;
		q16_t point_y;
		q16_t point_x;
	} pprr_in_t;

	typedef struct packed {
		q16_t weighted_distance;
		q16_t weighted_normal_z;
		q16_t weighted_normal_y;
		q16_t weighted_normal_x;
	} pprr_out_t;

	typedef struct packed {
		logic degenerate;
		logic keep;
	} pprr_flags_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
		logic [2:0][31:0]      dv;
	} plane_t;

	typedef struct packed {
		plane_t            plane;
		logic [ROOT_W-1:0] area_sq;
		logic [ROOT_W-1:0] depth_sq;
	} front_t;

	typedef struct packed {
		logic [2:0]       neg;
		logic             degen;
		logic [2:0][31:0] dv;
		logic [31:0]      depth;
	} nd_side_t;

	typedef struct packed {
		logic [2:0][N_W-1:0] n;
		logic [DIST_W-1:0]   plane_dist;
		logic                degen;
		logic                depth_zero;
		logic                ovf;
	} rd_side_t;

	function automatic q16_t sat_diff(input q16_t a, input q16_t b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		if (d > 33'(SAT_DIFF))
			return SAT_DIFF;
		else if (d < -33'(SAT_DIFF))
			return -SAT_DIFF;
		else
			return q16_t'(d[31:0]);
	endfunction

endpackage

FILE: rtl/core/pprr_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, several lanes
module pprr_sqrt_pipe #(
	parameter int W      = 64,
	parameter int LANES  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [LANES-1:0][W-1:0]     in_rad,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_vld,
	output logic [LANES-1:0][W/2-1:0]   out_root,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int STAGES = W / 2;

	logic [LANES-1:0][W-1:0] rem_s  [1:STAGES];
	logic [LANES-1:0][W-1:0] root_s [1:STAGES];
	logic [SIDE_W-1:0]       side_s [1:STAGES];
	logic                    vld_s  [1:STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (2 * (STAGES - 1 - k));
		logic [LANES-1:0][W-1:0] rem_in, root_in, rem_nx, root_nx;
		logic [SIDE_W-1:0]       side_in;
		logic                    vld_in;

		if (k == 0) begin : g_first
			assign rem_in  = in_rad;
			assign root_in = '0;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign side_in = side_s[k];
			assign vld_in  = vld_s[k];
		end

		always_comb begin
			logic [W-1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = root_in[l] + BIT;
				if (rem_in[l] >= trial) begin
					rem_nx[l]  = rem_in[l] - trial;
					root_nx[l] = (root_in[l] >> 1) + BIT;
				end else begin
					rem_nx[l]  = rem_in[l];
					root_nx[l] = root_in[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= root_nx;
				side_s[k+1] <= side_in;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++)
			out_root[l] = root_s[STAGES][l][W/2-1:0];
	end

	assign out_vld  = vld_s[STAGES];
	assign out_side = side_s[STAGES];

endmodule

FILE: rtl/core/pprr_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
module pprr_div_pipe #(
	parameter int NUM_W  = 60,
	parameter int DEN_W  = 32,
	parameter int Q_W    = 29,
	parameter int LANES  = 3,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [LANES-1:0][NUM_W-1:0]   in_num,
	input  logic [LANES-1:0][DEN_W-1:0]   in_den,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_vld,
	output logic [LANES-1:0][Q_W-1:0]     out_quo,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [LANES-1:0][CW-1:0]    rem_s  [1:Q_W];
	logic [LANES-1:0][DEN_W-1:0] den_s  [1:Q_W];
	logic [LANES-1:0][Q_W-1:0]   quo_s  [1:Q_W];
	logic [SIDE_W-1:0]           side_s [1:Q_W];
	logic                        vld_s  [1:Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int SH = Q_W - 1 - k;
		logic [LANES-1:0][CW-1:0]    rem_in, rem_nx;
		logic [LANES-1:0][DEN_W-1:0] den_in;
		logic [LANES-1:0][Q_W-1:0]   quo_in, quo_nx;
		logic [SIDE_W-1:0]           side_in;
		logic                        vld_in;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++)
					rem_in[l] = CW'(in_num[l]);
			end
			assign den_in  = in_den;
			assign quo_in  = '0;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign den_in  = den_s[k];
			assign quo_in  = quo_s[k];
			assign side_in = side_s[k];
			assign vld_in  = vld_s[k];
		end

		always_comb begin
			logic [CW-1:0] dsh;
			for (int l = 0; l < LANES; l++) begin
				dsh = CW'(den_in[l]) << SH;
				if (rem_in[l] >= dsh) begin
					rem_nx[l] = rem_in[l] - dsh;
					quo_nx[l] = quo_in[l] | (Q_W'(1) << SH);
				end else begin
					rem_nx[l] = rem_in[l];
					quo_nx[l] = quo_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nx;
				den_s[k+1]  <= den_in;
				quo_s[k+1]  <= quo_nx;
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[Q_W];
	assign out_quo  = quo_s[Q_W];
	assign out_side = side_s[Q_W];

endmodule

FILE: rtl/core/pprr_front.sv
// front pipeline: differences, cross product, block normalization and squares
module pprr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  pprr_pkg::pprr_in_t in_pt,
	output logic              out_vld,
	output pprr_pkg::front_t  out_f
);
	import pprr_pkg::*;

	q16_t pt [3];
	q16_t nr [3];
	q16_t ss [3];
	q16_t aj [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	q16_t u_s1 [3];
	q16_t v_s1 [3];
	q16_t dv_s1 [3];
	q16_t p_s1 [3];

	logic signed [63:0] pa_s2 [3];
	logic signed [63:0] pb_s2 [3];
	logic [63:0]        psq_s2 [3];
	q16_t               dv_s2 [3];

	logic signed [63:0] cr [3];
	logic [62:0]        mag_s3 [3];
	logic [2:0]         neg_s3;
	logic               degen_s3;
	logic [63:0]        depth_s3;
	q16_t               dv_s3 [3];

	logic [62:0] orv;
	logic [5:0]  pos;
	logic [5:0]  pos_s4;
	logic [62:0] mag_s4 [3];
	logic [2:0]  neg_s4;
	logic        degen_s4;
	logic [63:0] depth_s4;
	q16_t        dv_s4 [3];

	logic [MAG_W-1:0] nm [3];
	logic [MAG_W-1:0] mag_s5 [3];
	logic [2:0]       neg_s5;
	logic             degen_s5;
	logic [63:0]      depth_s5;
	q16_t             dv_s5 [3];

	logic [2*MAG_W-1:0] sq_s6 [3];
	logic [MAG_W-1:0]   mag_s6 [3];
	logic [2:0]         neg_s6;
	logic               degen_s6;
	logic [63:0]        depth_s6;
	q16_t               dv_s6 [3];

	logic [63:0]      area_s7;
	logic [MAG_W-1:0] mag_s7 [3];
	logic [2:0]       neg_s7;
	logic             degen_s7;
	logic [63:0]      depth_s7;
	q16_t             dv_s7 [3];

	assign pt[0] = in_pt.point_x;
	assign pt[1] = in_pt.point_y;
	assign pt[2] = in_pt.point_z;
	assign nr[0] = in_pt.near_x;
	assign nr[1] = in_pt.near_y;
	assign nr[2] = in_pt.near_z;
	assign ss[0] = in_pt.same_scan_x;
	assign ss[1] = in_pt.same_scan_y;
	assign ss[2] = in_pt.same_scan_z;
	assign aj[0] = in_pt.adjacent_scan_x;
	assign aj[1] = in_pt.adjacent_scan_y;
	assign aj[2] = in_pt.adjacent_scan_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// saturated differences against the nearest point
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s1[i]  <= sat_diff(ss[i], nr[i]);
				v_s1[i]  <= sat_diff(aj[i], nr[i]);
				dv_s1[i] <= sat_diff(pt[i], nr[i]);
				p_s1[i]  <= pt[i];
			end
		end
	end

	// cross product terms and range squares
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2[0] <= u_s1[1] * v_s1[2];
			pb_s2[0] <= u_s1[2] * v_s1[1];
			pa_s2[1] <= u_s1[2] * v_s1[0];
			pb_s2[1] <= u_s1[0] * v_s1[2];
			pa_s2[2] <= u_s1[0] * v_s1[1];
			pb_s2[2] <= u_s1[1] * v_s1[0];
			for (int i = 0; i < 3; i++) begin
				psq_s2[i] <= 64'(p_s1[i] * p_s1[i]);
				dv_s2[i]  <= dv_s1[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			cr[i] = pa_s2[i] - pb_s2[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s3[i] <= cr[i][63] ? 63'(-cr[i]) : 63'(cr[i]);
				neg_s3[i] <= cr[i][63];
				dv_s3[i]  <= dv_s2[i];
			end
			degen_s3 <= (cr[0] == 64'sd0) && (cr[1] == 64'sd0) && (cr[2] == 64'sd0);
			depth_s3 <= psq_s2[0] + psq_s2[1] + psq_s2[2];
		end
	end

	// leading one of the largest magnitude
	always_comb begin
		orv = mag_s3[0] | mag_s3[1] | mag_s3[2];
		pos = 6'd0;
		for (int i = 0; i < 63; i++)
			if (orv[i])
				pos = 6'(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s4   <= pos;
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
			degen_s4 <= degen_s3;
			depth_s4 <= depth_s3;
			dv_s4    <= dv_s3;
		end
	end

	// common shift so the largest lands in [2^29, 2^30)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s4 >= 6'd29)
				nm[i] = MAG_W'(mag_s4[i] >> (pos_s4 - 6'd29));
			else
				nm[i] = MAG_W'(mag_s4[i] << (6'd29 - pos_s4));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5   <= nm;
			neg_s5   <= neg_s4;
			degen_s5 <= degen_s4;
			depth_s5 <= depth_s4;
			dv_s5    <= dv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s6[i] <= mag_s5[i] * mag_s5[i];
			mag_s6   <= mag_s5;
			neg_s6   <= neg_s5;
			degen_s6 <= degen_s5;
			depth_s6 <= depth_s5;
			dv_s6    <= dv_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_s7  <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
			mag_s7   <= mag_s6;
			neg_s7   <= neg_s6;
			degen_s7 <= degen_s6;
			depth_s7 <= depth_s6;
			dv_s7    <= dv_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_f.plane.mag[i] = mag_s7[i];
			out_f.plane.dv[i]  = dv_s7[i];
		end
		out_f.plane.neg   = neg_s7;
		out_f.plane.degen = degen_s7;
		out_f.area_sq     = area_s7;
		out_f.depth_sq    = depth_s7;
	end

	assign out_vld = vld_s7;

endmodule

FILE: rtl/core/point_to_plane_residual_top.sv
// throughput: one request per cycle while the output is not stalled; the 32-stage two-lane root unit
// and the 29- and 33-stage divider pipelines set the depth, each handles one new request a cycle
// the whole pipeline holds while the output register is full and not taken
// reset clears every valid bit and the weighting mode register
// top level: point-to-plane residual pipeline with stream ports
module point_to_plane_residual_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data,   // robust_weighting
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, near_x, near_y, near_z, same_scan_x, same_scan_y,
	// same_scan_z, adjacent_scan_x, adjacent_scan_y, adjacent_scan_z
	input  logic [383:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// weighted_normal_x, weighted_normal_y, weighted_normal_z, weighted_distance
	output logic [127:0] m_tdata,
	// keep, degenerate
	output logic [1:0]   m_tuser
);
	import pprr_pkg::*;

	logic en;
	logic robust_q;

	logic   f_vld;
	front_t f_out;

	logic [1:0][ROOT_W-1:0]   sq_rad;
	logic [1:0][ROOT_W/2-1:0] sq_root;
	logic [$bits(plane_t)-1:0] sq_side;
	logic                     sq_vld;
	plane_t                   sq_pl;

	logic [2:0][NNUM_W-1:0] num_n1;
	logic [2:0][NDEN_W-1:0] den_n1;
	nd_side_t               side_n1;
	logic                   vld_n1;

	logic [2:0][NQ_W-1:0]        nd_quo;
	logic [$bits(nd_side_t)-1:0] nd_side_raw;
	nd_side_t                    nd_side;
	logic                        nd_vld;

	logic signed [N_W-1:0] n_c [3];
	logic signed [61:0]    prod_d1 [3];
	logic signed [N_W-1:0] n_d1 [3];
	logic                  degen_d1, vld_d1;
	logic [31:0]           depth_d1;

	logic signed [63:0]    d44_d2;
	logic signed [N_W-1:0] n_d2 [3];
	logic                  degen_d2, vld_d2;
	logic [31:0]           depth_d2;

	logic [62:0]              dmag;
	logic [62:0]              drnd;
	logic signed [DIST_W-1:0] dist_d3;
	logic signed [N_W-1:0]    n_d3 [3];
	logic                     degen_d3, vld_d3;
	logic [31:0]              depth_d3;

	logic [DIST_W-1:0] dabs;
	logic [RNUM_W-1:0] num_r0;
	logic [RDEN_W-1:0] den_r0;
	rd_side_t          side_r0;
	logic              vld_r0;

	logic [RNUM_W-1:0] num_r1;
	logic [RDEN_W-1:0] den_r1;
	rd_side_t          side_r1;
	logic              vld_r1;

	logic [0:0][RQ_W-1:0]        rd_quo;
	logic [$bits(rd_side_t)-1:0] rd_side_raw;
	rd_side_t                    rd_side;
	logic                        rd_vld;

	logic [RQ_W-1:0]          rsel;
	logic signed [35:0]       wide;
	q16_t                     wsel;
	q16_t                     w_w;
	logic signed [N_W-1:0]    n_w [3];
	logic signed [DIST_W-1:0] dist_w;
	logic                     degen_w, vld_w;

	logic signed [61:0] pn_m [3];
	logic signed [66:0] pd_m;
	logic               keep_m, degen_m, vld_m;

	pprr_out_t   data_o;
	pprr_flags_t flags_o;
	logic        vld_o;

	function automatic q16_t rnd_sat(input logic signed [66:0] v, input int unsigned sh);
		logic [66:0] mag;
		logic [66:0] rq;
		mag = v[66] ? 67'(-v) : 67'(v);
		rq  = (mag + (67'(1) << (sh - 1))) >> sh;
		if (v[66]) begin
			if (rq > 67'd2147483648)
				return SAT_NEG;
			else
				return q16_t'(32'(-rq));
		end else if (rq > 67'd2147483647) begin
			return SAT_POS;
		end else begin
			return q16_t'(rq[31:0]);
		end
	endfunction

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			robust_q <= 1'b0;
		else if (cfg_wr_en)
			robust_q <= cfg_wr_data;
	end

	pprr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.in_pt   (pprr_in_t'(s_tdata)),
		.out_vld (f_vld),
		.out_f   (f_out)
	);

	assign sq_rad[0] = f_out.area_sq;
	assign sq_rad[1] = f_out.depth_sq;

	// lane 0 gives the plane area, lane 1 the range of the point
	pprr_sqrt_pipe #(
		.W      (ROOT_W),
		.LANES  (2),
		.SIDE_W ($bits(plane_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.in_rad   (sq_rad),
		.in_side  (f_out.plane),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	assign sq_pl = plane_t'(sq_side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_n1 <= 1'b0;
			vld_d1 <= 1'b0;
			vld_d2 <= 1'b0;
			vld_d3 <= 1'b0;
			vld_r0 <= 1'b0;
			vld_r1 <= 1'b0;
			vld_w  <= 1'b0;
			vld_m  <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_n1 <= sq_vld;
			vld_d1 <= nd_vld;
			vld_d2 <= vld_d1;
			vld_d3 <= vld_d2;
			vld_r0 <= vld_d3;
			vld_r1 <= vld_r0;
			vld_w  <= rd_vld;
			vld_m  <= vld_w;
			vld_o  <= vld_m;
		end
	end

	// normal dividend and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_n1[i] <= (NNUM_W'(sq_pl.mag[i]) << 29) + NNUM_W'(sq_root[0]);
				den_n1[i] <= {sq_root[0][30:0], 1'b0};
			end
			side_n1.neg   <= sq_pl.neg;
			side_n1.degen <= sq_pl.degen;
			side_n1.dv    <= sq_pl.dv;
			side_n1.depth <= sq_root[1];
		end
	end

	pprr_div_pipe #(
		.NUM_W  (NNUM_W),
		.DEN_W  (NDEN_W),
		.Q_W    (NQ_W),
		.LANES  (3),
		.SIDE_W ($bits(nd_side_t))
	) u_ndiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_n1),
		.in_num   (num_n1),
		.in_den   (den_n1),
		.in_side  (side_n1),
		.out_vld  (nd_vld),
		.out_quo  (nd_quo),
		.out_side (nd_side_raw)
	);

	assign nd_side = nd_side_t'(nd_side_raw);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (nd_side.neg[i])
				n_c[i] = -$signed({1'b0, nd_quo[i]});
			else
				n_c[i] = $signed({1'b0, nd_quo[i]});
		end
	end

	// plane distance: products, sum, rounding to q16
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_d1[i] <= n_c[i] * $signed(nd_side.dv[i]);
				n_d1[i]    <= n_c[i];
			end
			degen_d1 <= nd_side.degen;
			depth_d1 <= nd_side.depth;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d44_d2   <= 64'(prod_d1[0]) + 64'(prod_d1[1]) + 64'(prod_d1[2]);
			n_d2     <= n_d1;
			degen_d2 <= degen_d1;
			depth_d2 <= depth_d1;
		end
	end

	always_comb begin
		dmag = d44_d2[63] ? 63'(-d44_d2) : 63'(d44_d2);
		drnd = (dmag + 63'd134217728) >> 28;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_d3  <= d44_d2[63] ? -$signed(DIST_W'(drnd)) : $signed(DIST_W'(drnd));
			n_d3     <= n_d2;
			degen_d3 <= degen_d2;
			depth_d3 <= depth_d2;
		end
	end

	// ratio dividend and divisor
	assign dabs = dist_d3[DIST_W-1] ? DIST_W'(-dist_d3) : DIST_W'(dist_d3);

	always_ff @(posedge clk) begin
		if (en) begin
			num_r0 <= RNUM_W'(dabs) * RNUM_W'(RATIO_MUL) + RNUM_W'(depth_d3) * RNUM_W'(5);
			den_r0 <= RDEN_W'(depth_d3) * RDEN_W'(10);
			for (int i = 0; i < 3; i++)
				side_r0.n[i] <= n_d3[i];
			side_r0.plane_dist <= dist_d3;
			side_r0.degen      <= degen_d3;
			side_r0.depth_zero <= (depth_d3 == 32'd0);
			side_r0.ovf        <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_r1  <= num_r0;
			den_r1  <= den_r0;
			side_r1 <= '{n: side_r0.n, plane_dist: side_r0.plane_dist,
				degen: side_r0.degen, depth_zero: side_r0.depth_zero,
				ovf: (69'(num_r0) >= {den_r0, {RQ_W{1'b0}}})};
		end
	end

	pprr_div_pipe #(
		.NUM_W  (RNUM_W),
		.DEN_W  (RDEN_W),
		.Q_W    (RQ_W),
		.LANES  (1),
		.SIDE_W ($bits(rd_side_t))
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_r1),
		.in_num   (num_r1),
		.in_den   (den_r1),
		.in_side  (side_r1),
		.out_vld  (rd_vld),
		.out_quo  (rd_quo),
		.out_side (rd_side_raw)
	);

	assign rd_side = rd_side_t'(rd_side_raw);

	// weight
	always_comb begin
		rsel = rd_side.ovf ? {RQ_W{1'b1}} : rd_quo[0];
		if (rd_side.plane_dist[DIST_W-1])
			wide = 36'sd65536 + $signed({3'b000, rsel});
		else
			wide = 36'sd65536 - $signed({3'b000, rsel});
		if (!robust_q)
			wsel = Q16_ONE;
		else if (rd_side.depth_zero)
			wsel = '0;
		else if (wide > 36'sd2147483647)
			wsel = SAT_POS;
		else if (wide < -36'sd2147483648)
			wsel = SAT_NEG;
		else
			wsel = q16_t'(wide[31:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_w <= wsel;
			for (int i = 0; i < 3; i++)
				n_w[i] <= $signed(rd_side.n[i]);
			dist_w  <= $signed(rd_side.plane_dist);
			degen_w <= rd_side.degen;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				pn_m[i] <= w_w * n_w[i];
			pd_m    <= w_w * dist_w;
			keep_m  <= (w_w > KEEP_MIN_W) && (dist_w > 35'sd0);
			degen_m <= degen_w;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (degen_m) begin
				data_o             <= '0;
				flags_o.keep       <= 1'b0;
				flags_o.degenerate <= 1'b1;
			end else begin
				data_o.weighted_normal_x <= rnd_sat(67'(pn_m[0]), 28);
				data_o.weighted_normal_y <= rnd_sat(67'(pn_m[1]), 28);
				data_o.weighted_normal_z <= rnd_sat(67'(pn_m[2]), 28);
				data_o.weighted_distance <= rnd_sat(pd_m, 16);
				flags_o.keep             <= keep_m;
				flags_o.degenerate       <= 1'b0;
			end
		end
	end

	assign m_tvalid = vld_o;
	assign m_tdata  = data_o;
	assign m_tuser  = flags_o;

`ifndef ASSERT_OFF
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == 128'd0) && !m_tuser[0])
		else $error("degenerate result with nonzero payload or keep");

	a_keep_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[127])
		else $error("kept result with negative weighted distance");

	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_m && m_tvalid && !m_tready |=> m_tvalid && vld_m)
		else $error("pipeline advanced while the output was stalled");
`endif

endmodule

FILE: verif/point_to_plane_residual_top_test.sv
// self-checking testbench for the point-to-plane residual pipeline
`timescale 1ns / 100ps

module point_to_plane_residual_top_test;
	import pprr_pkg::*;

	typedef struct packed {
		q16_t wd;
		q16_t nz;
		q16_t ny;
		q16_t nx;
		logic degen;
		logic keep;
	} residual_t;

	class residual_board;
		residual_t pending[$];
		bit robust;
		int mismatches;

		function longint sat_sub(longint a, longint b);
			longint d;
			d = a - b;
			if (d > 64'sd2147483647) d = 64'sd2147483647;
			if (d < -64'sd2147483647) d = -64'sd2147483647;
			return d;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function longint unsigned mag(longint v);
			return v < 0 ? 64'd0 - longint'(v) : v;
		endfunction

		function longint rmul(longint a, longint b, int sh);
			longint unsigned ua, ub, hi, lo, r;
			ua = mag(a);
			ub = mag(b);
			hi = ub >> sh;
			lo = ub & ((64'd1 << sh) - 1);
			r = ua * hi + ((ua * lo + (64'd1 << (sh - 1))) >> sh);
			return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
		endfunction

		function q16_t clip(longint v);
			if (v > 64'sd2147483647) return SAT_POS;
			if (v < -64'sd2147483648) return SAT_NEG;
			return q16_t'(v);
		endfunction

		function void note_request(pprr_in_t x);
			longint p[3], u[3], v[3], dv[3], c[3], n[3], d44, pdist, w, nr;
			longint unsigned mg[3], m, area, depth, q, num, r;
			residual_t e;
			d44 = 0;
			p[0] = x.point_x; p[1] = x.point_y; p[2] = x.point_z;
			for (int i = 0; i < 3; i++) begin
				nr = (i == 0) ? x.near_x : (i == 1) ? x.near_y : x.near_z;
				u[i] = sat_sub((i == 0) ? x.same_scan_x : (i == 1) ? x.same_scan_y
					: x.same_scan_z, nr);
				v[i] = sat_sub((i == 0) ? x.adjacent_scan_x : (i == 1) ? x.adjacent_scan_y
					: x.adjacent_scan_z, nr);
				dv[i] = sat_sub(p[i], nr);
			end
			c[0] = u[1] * v[2] - u[2] * v[1];
			c[1] = u[2] * v[0] - u[0] * v[2];
			c[2] = u[0] * v[1] - u[1] * v[0];
			e = '0;
			if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
				e.degen = 1;
				pending = {pending, e};
				return;
			end
			m = 0;
			for (int i = 0; i < 3; i++) begin
				mg[i] = mag(c[i]);
				if (mg[i] > m) m = mg[i];
			end
			while (m >= (64'd1 << 30)) begin
				m >>= 1;
				for (int i = 0; i < 3; i++) mg[i] >>= 1;
			end
			while (m < (64'd1 << 29)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++) mg[i] <<= 1;
			end
			area = root(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
			for (int i = 0; i < 3; i++) begin
				q = ((mg[i] << 29) + area) / (area * 2);
				n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
				d44 += n[i] * dv[i];
			end
			pdist = longint'((mag(d44) + (64'd1 << 27)) >> 28);
			if (d44 < 0) pdist = -pdist;
			if (!robust)
				w = 65536;
			else begin
				depth = root(mag(p[0]) * mag(p[0]) + mag(p[1]) * mag(p[1])
					+ mag(p[2]) * mag(p[2]));
				if (depth == 0)
					w = 0;
				else begin
					num = mag(pdist) * 64'd1179648 + 5 * depth;
					r = num / (10 * depth);
					w = 65536 - (pdist < 0 ? -longint'(r) : longint'(r));
					w = clip(w);
				end
			end
			e.nx = clip(rmul(w, n[0], 28));
			e.ny = clip(rmul(w, n[1], 28));
			e.nz = clip(rmul(w, n[2], 28));
			e.wd = clip(rmul(w, pdist, 16));
			e.keep = (w > 6553 && pdist > 0);
			pending = {pending, e};
		endfunction

		function void check_result(pprr_out_t o, logic [1:0] fl);
			residual_t e, a;
			a.nx = o.weighted_normal_x;
			a.ny = o.weighted_normal_y;
			a.nz = o.weighted_normal_z;
			a.wd = o.weighted_distance;
			a.keep = fl[0];
			a.degen = fl[1];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", a);
				return;
			end
			e = pending.pop_front();
			if (a !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: nx %h/%h ny %h/%h nz %h/%h wd %h/%h keep %b/%b deg %b/%b",
						e.nx, a.nx, e.ny, a.ny, e.nz, a.nz, e.wd, a.wd,
						e.keep, a.keep, e.degen, a.degen);
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_wr_en, cfg_wr_data, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [383:0] s_tdata;
	logic [127:0] m_tdata;
	logic [1:0] m_tuser;
	residual_board board;
	int send_idle, recv_stall, quiet;

	point_to_plane_residual_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			quiet = 0;
		else
			quiet++;
		if (quiet > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall);

	function automatic q16_t rand_coord(int kind);
		case (kind)
			0: return q16_t'($urandom);
			1: return q16_t'($urandom_range(20 * 65536)) - 10 * 65536;
			default: return q16_t'($urandom_range(400 * 65536)) - 200 * 65536;
		endcase
	endfunction

	task automatic send(pprr_in_t x);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= x;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(x);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic set_mode(bit val);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 0;
		board.robust = val;
	endtask

	task automatic send_random(int kind);
		pprr_in_t x;
		x = pprr_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		if (kind != 0) begin
			x.point_x = rand_coord(kind); x.point_y = rand_coord(kind);
			x.point_z = rand_coord(kind); x.near_x = rand_coord(kind);
			x.near_y = rand_coord(kind); x.near_z = rand_coord(kind);
			x.same_scan_x = x.near_x + rand_coord(1) / 8;
			x.same_scan_y = x.near_y + rand_coord(1) / 8;
			x.same_scan_z = x.near_z + rand_coord(1) / 8;
			x.adjacent_scan_x = x.near_x + rand_coord(1) / 8;
			x.adjacent_scan_y = x.near_y + rand_coord(1) / 8;
			x.adjacent_scan_z = x.near_z + rand_coord(1) / 8;
			if ($urandom_range(9) == 0) x.adjacent_scan_y = x.same_scan_y;
		end
		send(x);
	endtask

	task automatic directed();
		pprr_in_t x;
		x = '0;
		send(x);
		x.same_scan_x = 65536; x.adjacent_scan_y = 65536; x.point_z = 65536;
		send(x);
		x.point_z = -65536;
		send(x);
		x.point_z = 0;
		send(x);
		x.adjacent_scan_x = 131072; x.adjacent_scan_y = 0;
		send(x);
		x = '0;
		x.same_scan_x = SAT_POS; x.adjacent_scan_y = SAT_NEG; x.near_z = SAT_NEG;
		x.point_x = SAT_POS; x.point_y = SAT_NEG;
		send(x);
		x = '1;
		x.near_x = SAT_POS; x.same_scan_y = SAT_NEG; x.adjacent_scan_z = SAT_POS;
		send(x);
		x = '0;
		x.same_scan_x = 1; x.adjacent_scan_y = 1; x.point_z = 40 * 65536;
		send(x);
		x.point_z = 1;
		send(x);
		x.point_z = -SAT_POS;
		send(x);
		x = '1;
		send(x);
		x = '0;
		x.same_scan_x = 65536; x.adjacent_scan_y = 65536;
		x.point_x = 65536 * 3; x.point_z = 65536;
		send(x);
		x.point_z = 65536 * 1000;
		send(x);
	endtask

	initial begin
		board = new();
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		send_idle = 0;
		recv_stall = 0;
		quiet = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		directed();
		drain();
		set_mode(1);
		directed();
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 58; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 58; end
				default: begin send_idle = 20; recv_stall = 20; end
			endcase
			set_mode(ph[0] ^ ph[2]);
			for (int i = 0; i < 140; i++) send_random($urandom_range(9) == 0 ? 0 :
				$urandom_range(1, 2));
			drain();
		end
		if (board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
